>>> design/lcd_pkg.sv
// Shared types and constants for the loop chunk dispatcher.
`timescale 1ns / 1ps

package lcd_pkg;

   localparam int DEF_MAX_WORKERS = 16;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_SCHEDULE_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHUNK_SIZE    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TEAM_REQUEST  = 2'd2;

   localparam logic [6:0] TEAM_REQUEST_RESET = 7'd16;

   typedef enum logic [1:0] {
      MODE_STATIC  = 2'd0,
      MODE_DYNAMIC = 2'd1,
      MODE_GUIDED  = 2'd2,
      MODE_STEAL   = 2'd3
   } mode_type;

   typedef enum logic {
      OP_START = 1'b0,
      OP_CLAIM = 1'b1
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_FILL,
      ST_DYN,
      ST_GUIDE,
      ST_GUIDE_FIN,
      ST_STATIC_EV,
      ST_STEAL_RD,
      ST_STEAL_EV,
      ST_RESP
   } state_type;

endpackage

>>> design/loop_chunk_dispatcher.sv
// Loop chunk dispatcher: sequencer around one shared divider and one share memory.
`timescale 1ns / 1ps
// A start item runs the 32-step restoring divider, then one share write per team
//   member; a dynamic or static claim is one evaluation, a guided claim runs the
//   divider again; a steal claim tries the own share first, else scans the team
//   with one memory read and one evaluation per member scanned.
// Throughput: one item at a time; the next item is taken once the result is loaded
//   into the output register. Reset clears control, configuration and job state.

module loop_chunk_dispatcher #(
   parameter int MAX_WORKERS = lcd_pkg::DEF_MAX_WORKERS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_op,
   input  logic [5:0]                    req_worker_id,
   input  logic signed [31:0]            req_loop_first,
   input  logic signed [31:0]            req_loop_limit,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_granted,
   output logic signed [31:0]            rsp_range_begin,
   output logic signed [31:0]            rsp_range_end,
   output logic                          rsp_job_done,
   output logic [6:0]                    rsp_team_in_use,
   input  logic                          csr_we,
   input  logic [lcd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                   csr_wdata
);

   localparam int IDX_W = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
   localparam logic [6:0] MAX_W7 = 7'(MAX_WORKERS);

   lcd_pkg::state_type state_ff, state_in;

   lcd_pkg::mode_type mode_ff;
   logic [31:0]       chunk_ff;
   logic [6:0]        team_req_ff;

   logic [31:0] origin_ff, origin_in;
   logic [31:0] trip_ff, trip_in;
   logic [31:0] shared_ff, shared_in;
   logic [6:0]  team_ff, team_in;

   logic [5:0]       who_ff, who_in;
   logic             own_ff, own_in;
   logic [6:0]       scan_ff, scan_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [31:0]      fill_pos_ff, fill_pos_in;
   logic             is_start_ff, is_start_in;

   logic [31:0] div_q_ff, div_q_in;
   logic [6:0]  div_r_ff, div_r_in;
   logic [6:0]  div_d_ff, div_d_in;
   logic [4:0]  div_cnt_ff, div_cnt_in;

   logic        res_granted_ff, res_granted_in;
   logic        res_done_ff, res_done_in;
   logic [31:0] res_lo_ff, res_lo_in;
   logic [31:0] res_hi_ff, res_hi_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_granted_ff, rsp_granted_in;
   logic [31:0] rsp_begin_ff, rsp_begin_in;
   logic [31:0] rsp_end_ff, rsp_end_in;
   logic        rsp_done_ff, rsp_done_in;
   logic [6:0]  rsp_team_ff, rsp_team_in;

   // share memory: {cursor, end} per team member, offsets from the job origin
   logic [63:0]      share_mem [MAX_WORKERS];
   logic [63:0]      mem_rd_ff;
   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   logic [63:0]      mem_wdata;
   logic [IDX_W-1:0] mem_raddr;

   logic [32:0] span;
   logic        span_pos;
   logic [6:0]  team_cap;
   logic [6:0]  team_clamp;
   logic [31:0] step;
   logic [7:0]  div_tmp;
   logic        div_ge;
   logic [7:0]  div_sub;
   logic [31:0] fill_cnt;
   logic [31:0] fill_next;
   logic [31:0] rd_cur;
   logic [31:0] rd_end;
   logic [32:0] steal_sum;
   logic [31:0] steal_stop;
   logic [32:0] dyn_sum;
   logic [31:0] dyn_stop;
   logic [31:0] piece;
   logic        accept;

   assign req_ready = (state_ff == lcd_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_granted     = rsp_granted_ff;
   assign rsp_range_begin = rsp_begin_ff;
   assign rsp_range_end   = rsp_end_ff;
   assign rsp_job_done    = rsp_done_ff;
   assign rsp_team_in_use = rsp_team_ff;

   // datapath helpers
   assign span     = {req_loop_limit[31], req_loop_limit} - {req_loop_first[31], req_loop_first};
   assign span_pos = !span[32] && (span[31:0] != 32'd0);
   assign team_cap = (team_req_ff > MAX_W7) ? MAX_W7 : team_req_ff;

   always_comb begin
      team_clamp = team_cap;
      if (span[31:0] < {25'd0, team_cap}) begin
         team_clamp = span[6:0];
      end
      if (team_clamp == 7'd0) begin
         team_clamp = 7'd1;
      end
   end

   assign step    = (chunk_ff == 32'd0) ? 32'd1 : chunk_ff;
   assign div_tmp = {div_r_ff, div_q_ff[31]};
   assign div_ge  = (div_tmp >= {1'b0, div_d_ff});
   assign div_sub = div_tmp - {1'b0, div_d_ff};

   assign fill_cnt  = div_q_ff + {31'd0, (scan_ff < div_r_ff)};
   assign fill_next = fill_pos_ff + fill_cnt;

   assign rd_cur     = mem_rd_ff[63:32];
   assign rd_end     = mem_rd_ff[31:0];
   assign steal_sum  = {1'b0, rd_cur} + {1'b0, step};
   assign steal_stop = (steal_sum > {1'b0, rd_end}) ? rd_end : steal_sum[31:0];
   assign dyn_sum    = {1'b0, shared_ff} + {1'b0, step};
   assign dyn_stop   = (dyn_sum > {1'b0, trip_ff}) ? trip_ff : dyn_sum[31:0];
   assign piece      = (div_q_ff == 32'd0) ? 32'd1 : div_q_ff;

   always_comb begin
      state_in       = state_ff;
      origin_in      = origin_ff;
      trip_in        = trip_ff;
      shared_in      = shared_ff;
      team_in        = team_ff;
      who_in         = who_ff;
      own_in         = own_ff;
      scan_in        = scan_ff;
      idx_in         = idx_ff;
      fill_pos_in    = fill_pos_ff;
      is_start_in    = is_start_ff;
      div_q_in       = div_q_ff;
      div_r_in       = div_r_ff;
      div_d_in       = div_d_ff;
      div_cnt_in     = div_cnt_ff;
      res_granted_in = res_granted_ff;
      res_done_in    = res_done_ff;
      res_lo_in      = res_lo_ff;
      res_hi_in      = res_hi_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_granted_in = rsp_granted_ff;
      rsp_begin_in   = rsp_begin_ff;
      rsp_end_in     = rsp_end_ff;
      rsp_done_in    = rsp_done_ff;
      rsp_team_in    = rsp_team_ff;
      mem_we         = 1'b0;
      mem_waddr      = idx_ff;
      mem_wdata      = mem_rd_ff;
      mem_raddr      = idx_ff;

      unique case (state_ff)
         lcd_pkg::ST_IDLE: begin
            if (accept) begin
               res_granted_in = 1'b0;
               res_done_in    = 1'b1;
               if (lcd_pkg::op_type'(req_op) == lcd_pkg::OP_START) begin
                  origin_in = req_loop_first;
                  shared_in = 32'd0;
                  if (!span_pos) begin
                     trip_in  = 32'd0;
                     team_in  = 7'd0;
                     state_in = lcd_pkg::ST_RESP;
                  end else begin
                     trip_in     = span[31:0];
                     team_in     = team_clamp;
                     div_q_in    = span[31:0];
                     div_r_in    = 7'd0;
                     div_d_in    = team_clamp;
                     div_cnt_in  = 5'd0;
                     is_start_in = 1'b1;
                     res_done_in = 1'b0;
                     state_in    = lcd_pkg::ST_DIV;
                  end
               end else begin
                  who_in    = req_worker_id;
                  idx_in    = IDX_W'(req_worker_id);
                  mem_raddr = IDX_W'(req_worker_id);
                  unique case (mode_ff)
                     lcd_pkg::MODE_STATIC: begin
                        if ({1'b0, req_worker_id} < team_ff) begin
                           state_in = lcd_pkg::ST_STATIC_EV;
                        end else begin
                           state_in = lcd_pkg::ST_RESP;
                        end
                     end
                     lcd_pkg::MODE_DYNAMIC: state_in = lcd_pkg::ST_DYN;
                     lcd_pkg::MODE_GUIDED:  state_in = lcd_pkg::ST_GUIDE;
                     lcd_pkg::MODE_STEAL: begin
                        scan_in = 7'd0;
                        if ({1'b0, req_worker_id} < team_ff) begin
                           own_in   = 1'b1;
                           state_in = lcd_pkg::ST_STEAL_EV;
                        end else begin
                           own_in   = 1'b0;
                           state_in = lcd_pkg::ST_STEAL_RD;
                        end
                     end
                  endcase
               end
            end
         end

         lcd_pkg::ST_DIV: begin
            // one quotient bit per cycle
            div_q_in   = {div_q_ff[30:0], div_ge};
            div_r_in   = div_ge ? div_sub[6:0] : div_tmp[6:0];
            div_cnt_in = div_cnt_ff + 5'd1;
            if (div_cnt_ff == 5'd31) begin
               if (is_start_ff) begin
                  scan_in     = 7'd0;
                  fill_pos_in = 32'd0;
                  state_in    = lcd_pkg::ST_FILL;
               end else begin
                  state_in = lcd_pkg::ST_GUIDE_FIN;
               end
            end
         end

         lcd_pkg::ST_FILL: begin
            mem_we      = 1'b1;
            mem_waddr   = scan_ff[IDX_W-1:0];
            mem_wdata   = {fill_pos_ff, fill_next};
            fill_pos_in = fill_next;
            scan_in     = scan_ff + 7'd1;
            if (scan_ff == team_ff - 7'd1) begin
               state_in = lcd_pkg::ST_RESP;
            end
         end

         lcd_pkg::ST_DYN: begin
            if (shared_ff < trip_ff) begin
               res_granted_in = 1'b1;
               res_done_in    = 1'b0;
               res_lo_in      = shared_ff;
               res_hi_in      = dyn_stop;
               shared_in      = dyn_stop;
            end
            state_in = lcd_pkg::ST_RESP;
         end

         lcd_pkg::ST_GUIDE: begin
            if (shared_ff < trip_ff) begin
               div_q_in    = trip_ff - shared_ff;
               div_r_in    = 7'd0;
               div_d_in    = (team_ff == 7'd0) ? 7'd1 : team_ff;
               div_cnt_in  = 5'd0;
               is_start_in = 1'b0;
               state_in    = lcd_pkg::ST_DIV;
            end else begin
               state_in = lcd_pkg::ST_RESP;
            end
         end

         lcd_pkg::ST_GUIDE_FIN: begin
            res_granted_in = 1'b1;
            res_done_in    = 1'b0;
            res_lo_in      = shared_ff;
            res_hi_in      = shared_ff + piece;
            shared_in      = shared_ff + piece;
            state_in       = lcd_pkg::ST_RESP;
         end

         lcd_pkg::ST_STATIC_EV: begin
            if (rd_cur < rd_end) begin
               res_granted_in = 1'b1;
               res_done_in    = 1'b0;
               res_lo_in      = rd_cur;
               res_hi_in      = rd_end;
               mem_we         = 1'b1;
               mem_wdata      = {rd_end, rd_end};
            end
            state_in = lcd_pkg::ST_RESP;
         end

         lcd_pkg::ST_STEAL_RD: begin
            priority if (scan_ff >= team_ff) begin
               state_in = lcd_pkg::ST_RESP;
            end else if (scan_ff == {1'b0, who_ff}) begin
               scan_in = scan_ff + 7'd1;
            end else begin
               idx_in    = scan_ff[IDX_W-1:0];
               mem_raddr = scan_ff[IDX_W-1:0];
               state_in  = lcd_pkg::ST_STEAL_EV;
            end
         end

         lcd_pkg::ST_STEAL_EV: begin
            if (rd_cur < rd_end) begin
               res_granted_in = 1'b1;
               res_done_in    = 1'b0;
               res_lo_in      = rd_cur;
               res_hi_in      = steal_stop;
               mem_we         = 1'b1;
               mem_wdata      = {steal_stop, rd_end};
               state_in       = lcd_pkg::ST_RESP;
            end else begin
               // share empty: after the own share scan from member 0, else go on
               if (own_ff) begin
                  own_in  = 1'b0;
                  scan_in = 7'd0;
               end else begin
                  scan_in = scan_ff + 7'd1;
               end
               state_in = lcd_pkg::ST_STEAL_RD;
            end
         end

         lcd_pkg::ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_granted_in = res_granted_ff;
               rsp_begin_in   = res_granted_ff ? origin_ff + res_lo_ff : 32'd0;
               rsp_end_in     = res_granted_ff ? origin_ff + res_hi_ff : 32'd0;
               rsp_done_in    = res_done_ff;
               rsp_team_in    = team_ff;
               state_in       = lcd_pkg::ST_IDLE;
            end
         end

         default: state_in = lcd_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lcd_pkg::ST_IDLE;
         origin_ff    <= 32'd0;
         trip_ff      <= 32'd0;
         shared_ff    <= 32'd0;
         team_ff      <= 7'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         origin_ff    <= origin_in;
         trip_ff      <= trip_in;
         shared_ff    <= shared_in;
         team_ff      <= team_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      who_ff         <= who_in;
      own_ff         <= own_in;
      scan_ff        <= scan_in;
      idx_ff         <= idx_in;
      fill_pos_ff    <= fill_pos_in;
      is_start_ff    <= is_start_in;
      div_q_ff       <= div_q_in;
      div_r_ff       <= div_r_in;
      div_d_ff       <= div_d_in;
      div_cnt_ff     <= div_cnt_in;
      res_granted_ff <= res_granted_in;
      res_done_ff    <= res_done_in;
      res_lo_ff      <= res_lo_in;
      res_hi_ff      <= res_hi_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_begin_ff   <= rsp_begin_in;
      rsp_end_ff     <= rsp_end_in;
      rsp_done_ff    <= rsp_done_in;
      rsp_team_ff    <= rsp_team_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= lcd_pkg::MODE_STATIC;
         chunk_ff    <= 32'd0;
         team_req_ff <= lcd_pkg::TEAM_REQUEST_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            lcd_pkg::CSR_SCHEDULE_MODE: mode_ff     <= lcd_pkg::mode_type'(csr_wdata[1:0]);
            lcd_pkg::CSR_CHUNK_SIZE:    chunk_ff    <= csr_wdata;
            lcd_pkg::CSR_TEAM_REQUEST:  team_req_ff <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   // entries at or above the team size are never used, so no clearing is needed
   always_ff @(posedge clock) begin
      if (mem_we) begin
         share_mem[mem_waddr] <= mem_wdata;
      end
      mem_rd_ff <= share_mem[mem_raddr];
   end

endmodule

>>> tb/tb_loop_chunk_dispatcher.sv
// Self-checking testbench for the loop chunk dispatcher: directed and random start/claim traffic.
`timescale 1ns / 1ps

module tb_loop_chunk_dispatcher;

   localparam int MAX_W        = lcd_pkg::DEF_MAX_WORKERS;
   localparam int RANDOM_ITEMS = 1400;
   localparam int LONG_HOLD    = 300;
   localparam int CYCLE_LIMIT  = 800000;

   typedef struct packed {
      logic               granted;
      logic signed [31:0] range_begin;
      logic signed [31:0] range_end;
      logic               job_done;
      logic [6:0]         team_in_use;
   } grant_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic                          req_op = 1'b0;
   logic [5:0]                    req_worker_id = '0;
   logic signed [31:0]            req_loop_first = '0;
   logic signed [31:0]            req_loop_limit = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic                          rsp_granted;
   logic signed [31:0]            rsp_range_begin;
   logic signed [31:0]            rsp_range_end;
   logic                          rsp_job_done;
   logic [6:0]                    rsp_team_in_use;
   logic                          csr_we = 1'b0;
   logic [lcd_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0]                   csr_wdata = '0;

   // predicted dispatcher state
   lcd_pkg::mode_type cfg_mode = lcd_pkg::MODE_STATIC;
   logic [31:0]       cfg_chunk = '0;
   logic [6:0]        cfg_team = lcd_pkg::TEAM_REQUEST_RESET;
   logic [31:0]       job_base = '0;
   logic [31:0]       job_trips = '0;
   logic [31:0]       common_pos = '0;
   logic [6:0]        team_now = '0;
   logic [31:0]       own_pos [MAX_W];
   logic [31:0]       own_end [MAX_W];

   grant_type grant_q [$];

   int mismatches = 0;
   int items_sent = 0;
   int starts_sent = 0;
   int results_seen = 0;
   int settings_used = 0;
   int cycle_count = 0;
   int claims_by_mode [4];
   int grants_by_mode [4];

   // sender and receiver pacing
   bit   bursty = 1'b1;
   bit   stall_on = 1'b1;
   int   burst_left = 0;
   int   hold_requests = 0;
   int   holds_started = 0;
   int   hold_left = 0;
   int   run_left = 0;
   bit   ready_phase = 1'b1;

   loop_chunk_dispatcher u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_worker_id   (req_worker_id),
      .req_loop_first  (req_loop_first),
      .req_loop_limit  (req_loop_limit),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_granted     (rsp_granted),
      .rsp_range_begin (rsp_range_begin),
      .rsp_range_end   (rsp_range_end),
      .rsp_job_done    (rsp_job_done),
      .rsp_team_in_use (rsp_team_in_use),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      for (int k = 0; k < MAX_W; k++) begin
         own_pos[k] = '0;
         own_end[k] = '0;
      end
      for (int m = 0; m < 4; m++) begin
         claims_by_mode[m] = 0;
         grants_by_mode[m] = 0;
      end
   end

   function automatic logic [63:0] chunk_step();
      return (cfg_chunk == 0) ? 64'd1 : {32'd0, cfg_chunk};
   endfunction

   // advance one member's share cursor by one chunk
   function automatic bit take_share(int k, output logic [63:0] lo, output logic [63:0] hi);
      logic [63:0] stop;
      lo = '0;
      hi = '0;
      if (k >= MAX_W || k >= team_now) return 1'b0;
      if (own_pos[k] >= own_end[k]) return 1'b0;
      stop = 64'(own_pos[k]) + chunk_step();
      if (stop > 64'(own_end[k])) stop = 64'(own_end[k]);
      lo = 64'(own_pos[k]);
      hi = stop;
      own_pos[k] = stop[31:0];
      return 1'b1;
   endfunction

   function automatic grant_type predict_dispatch(lcd_pkg::op_type op, logic [5:0] wid,
                                                  logic signed [31:0] first,
                                                  logic signed [31:0] limit);
      grant_type   g;
      longint      span;
      logic [63:0] lo, hi, pos, stop, left, piece, divisor;
      logic [31:0] n, q, r, cursor, cnt;
      bit          got;
      int          k;
      g = '0;
      lo = '0;
      hi = '0;
      got = 1'b0;
      if (op == lcd_pkg::OP_START) begin
         for (k = 0; k < MAX_W; k++) begin
            own_pos[k] = '0;
            own_end[k] = '0;
         end
         job_base = first;
         common_pos = '0;
         span = longint'(limit) - longint'(first);
         if (span <= 0) begin
            job_trips = '0;
            team_now = '0;
         end else begin
            job_trips = span[31:0];
            n = {25'd0, cfg_team};
            if (n > MAX_W) n = MAX_W;
            if (n > job_trips) n = job_trips;
            if (n < 1) n = 1;
            team_now = n[6:0];
            q = job_trips / n;
            r = job_trips % n;
            cursor = '0;
            for (k = 0; k < n; k++) begin
               cnt = q + ((k < r) ? 32'd1 : 32'd0);
               own_pos[k] = cursor;
               own_end[k] = cursor + cnt;
               cursor += cnt;
            end
         end
         g.job_done = (job_trips == 0);
         g.team_in_use = team_now;
         starts_sent++;
         return g;
      end
      claims_by_mode[int'(cfg_mode)]++;
      case (cfg_mode)
         lcd_pkg::MODE_STATIC: begin
            if (wid < MAX_W && wid < team_now && own_pos[wid] < own_end[wid]) begin
               lo = 64'(own_pos[wid]);
               hi = 64'(own_end[wid]);
               own_pos[wid] = own_end[wid];
               got = 1'b1;
            end
         end
         lcd_pkg::MODE_DYNAMIC: begin
            pos = 64'(common_pos);
            if (pos < 64'(job_trips)) begin
               stop = pos + chunk_step();
               if (stop > 64'(job_trips)) stop = 64'(job_trips);
               common_pos = stop[31:0];
               lo = pos;
               hi = stop;
               got = 1'b1;
            end
         end
         lcd_pkg::MODE_GUIDED: begin
            pos = 64'(common_pos);
            if (pos < 64'(job_trips)) begin
               left = 64'(job_trips) - pos;
               divisor = (team_now != 0) ? 64'(team_now) : 64'd1;
               piece = left / divisor;
               if (piece < 1) piece = 1;
               common_pos = 32'(pos + piece);
               lo = pos;
               hi = pos + piece;
               got = 1'b1;
            end
         end
         default: begin
            // own share first, then the lowest other member with work left
            got = take_share(wid, lo, hi);
            for (k = 0; k < team_now && k < MAX_W && !got; k++) begin
               if (k != wid) got = take_share(k, lo, hi);
            end
         end
      endcase
      if (got) begin
         grants_by_mode[int'(cfg_mode)]++;
         g.granted = 1'b1;
         g.range_begin = job_base + lo[31:0];
         g.range_end = job_base + hi[31:0];
      end else begin
         g.job_done = 1'b1;
      end
      g.team_in_use = team_now;
      return g;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
      $display("%0t ns: %s mismatch, expected %h, got %h", $time, what, want, got);
      mismatches++;
   endtask

   // one transaction on the request channel; valid stays up while a burst goes on
   task automatic send_item(lcd_pkg::op_type op, logic [5:0] wid,
                            logic signed [31:0] first, logic signed [31:0] limit);
      int gap;
      if (burst_left == 0) begin
         gap = (!bursty || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_op <= op;
      req_worker_id <= wid;
      req_loop_first <= first;
      req_loop_limit <= limit;
      do @(posedge clock); while (!req_ready);
      grant_q.push_back(predict_dispatch(op, wid, first, limit));
      items_sent++;
   endtask

   task automatic start_job(logic signed [31:0] first, logic signed [31:0] limit);
      send_item(lcd_pkg::OP_START, 6'($urandom), first, limit);
   endtask

   task automatic claim_for(logic [5:0] wid);
      send_item(lcd_pkg::OP_CLAIM, wid, $urandom, $urandom);
   endtask

   // drop valid and hold until every pending result has been taken
   task automatic wait_idle();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (grant_q.size() != 0);
   endtask

   task automatic configure(lcd_pkg::mode_type mode, logic [31:0] chunk, logic [6:0] team);
      csr_we <= 1'b1;
      csr_index <= lcd_pkg::CSR_SCHEDULE_MODE;
      csr_wdata <= {30'd0, mode};
      @(posedge clock);
      cfg_mode = mode;
      csr_index <= lcd_pkg::CSR_CHUNK_SIZE;
      csr_wdata <= chunk;
      @(posedge clock);
      cfg_chunk = chunk;
      csr_index <= lcd_pkg::CSR_TEAM_REQUEST;
      csr_wdata <= {25'd0, team};
      @(posedge clock);
      cfg_team = team;
      csr_we <= 1'b0;
      settings_used++;
   endtask

   task automatic test_idle_claims();
      claim_for(6'd0);
      start_job(32'sd7, 32'sd7);
      claim_for(6'd3);
      wait_idle();
   endtask

   task automatic test_static();
      configure(lcd_pkg::MODE_STATIC, 32'd0, 7'd16);
      start_job(32'sd0, 32'sd100);
      claim_for(6'd3);
      claim_for(6'd4);
      claim_for(6'd20);
      claim_for(6'd3);
      wait_idle();
      // full signed span with an oversized team request
      configure(lcd_pkg::MODE_STATIC, 32'd0, 7'd127);
      start_job(32'sh8000_0000, 32'sh7FFF_FFFF);
      claim_for(6'd15);
      wait_idle();
   endtask

   task automatic test_dynamic();
      configure(lcd_pkg::MODE_DYNAMIC, 32'd0, 7'd1);
      start_job(-32'sd10, -32'sd7);
      repeat (4) claim_for(6'd5);
      wait_idle();
      configure(lcd_pkg::MODE_DYNAMIC, 32'hFFFF_FFFF, 7'd64);
      start_job(32'sh7FFF_FFF8, 32'sh7FFF_FFFF);
      claim_for(6'd63);
      wait_idle();
   endtask

   task automatic test_guided();
      configure(lcd_pkg::MODE_GUIDED, 32'd0, 7'd0);
      start_job(32'sd0, 32'sd9);
      claim_for(6'd0);
      start_job(32'sd100, 32'sd90);
      claim_for(6'd1);
      wait_idle();
   endtask

   task automatic test_steal();
      configure(lcd_pkg::MODE_STEAL, 32'd3, 7'd4);
      start_job(32'sd0, 32'sd20);
      claim_for(6'd1);
      claim_for(6'd1);
      claim_for(6'd1);
      claim_for(6'd40);
      wait_idle();
   endtask

   task automatic test_mode_switch();
      // keep the steal job and serve it from the shared cursor
      configure(lcd_pkg::MODE_DYNAMIC, 32'd3, 7'd4);
      claim_for(6'd9);
      wait_idle();
   endtask

   task automatic test_backpressure();
      bursty = 1'b0;
      stall_on = 1'b1;
      configure(lcd_pkg::MODE_DYNAMIC, 32'd2, 7'd8);
      hold_requests++;
      start_job(32'sd0, 32'sd30);
      repeat (12) claim_for(6'($urandom_range(0, 9)));
      wait_idle();
      bursty = 1'b1;
   endtask

   task automatic test_random();
      int                 goal, n_claims;
      lcd_pkg::mode_type  mode;
      logic [31:0]        chunk;
      logic [6:0]         team;
      logic signed [31:0] first, limit;
      logic [63:0]        est;
      logic [5:0]         wid;
      goal = items_sent + RANDOM_ITEMS;
      while (items_sent < goal) begin
         mode = lcd_pkg::mode_type'($urandom_range(0, 3));
         case ($urandom_range(0, 5))
            0:       chunk = '0;
            1:       chunk = 32'd1;
            2:       chunk = $urandom_range(2, 8);
            3:       chunk = $urandom_range(9, 40);
            4:       chunk = 32'hFFFF_FFFF;
            default: chunk = $urandom;
         endcase
         case ($urandom_range(0, 7))
            0:       team = 7'd0;
            1:       team = 7'd1;
            2:       team = 7'($urandom_range(65, 127));
            3:       team = 7'($urandom_range(17, 64));
            default: team = 7'($urandom_range(2, 16));
         endcase
         bursty = ($urandom_range(0, 3) != 0);
         stall_on = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 15) == 0) hold_requests++;
         configure(mode, chunk, team);
         repeat ($urandom_range(1, 3)) begin
            // now and then run the new setting on what the last job left over
            if (team_now == 0 || $urandom_range(0, 5) != 0) begin
               case ($urandom_range(0, 9))
                  0: begin
                     first = $urandom;
                     limit = $urandom;
                  end
                  1: begin
                     first = 32'sh8000_0000 + $urandom_range(0, 3);
                     limit = first + $urandom_range(1, 40);
                  end
                  2: begin
                     limit = 32'sh7FFF_FFFF - $urandom_range(0, 3);
                     first = limit - $urandom_range(1, 40);
                  end
                  3: begin
                     first = $urandom;
                     limit = first - $urandom_range(0, 3);
                  end
                  default: begin
                     first = $urandom;
                     limit = first + $urandom_range(1, 48);
                  end
               endcase
               start_job(first, limit);
            end
            est = (mode == lcd_pkg::MODE_STATIC) ? 64'd0 : job_trips / chunk_step();
            n_claims = team_now + 4 + ((est > 40) ? 40 : int'(est));
            repeat (n_claims) begin
               if ($urandom_range(0, 4) == 0) wid = 6'($urandom_range(0, 63));
               else wid = 6'($urandom_range(0, team_now + 1));
               claim_for(wid);
            end
         end
         wait_idle();
      end
   endtask

   // receiver: random ready/stall runs, plus an occasional long hold
   always @(posedge clock) begin
      if (hold_requests != holds_started) begin
         holds_started = hold_requests;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (!stall_on) begin
         rsp_ready <= 1'b1;
      end else begin
         if (run_left == 0) begin
            ready_phase = !ready_phase;
            run_left = ready_phase ? $urandom_range(1, 10) : $urandom_range(1, 8);
         end
         run_left--;
         rsp_ready <= ready_phase;
      end
   end

   always @(posedge clock) begin : check_results
      grant_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (grant_q.size() == 0) begin
            report_mismatch("unexpected result", 32'd0, 32'd1);
         end else begin
            want = grant_q.pop_front();
            if (rsp_granted !== want.granted)
               report_mismatch("granted", 32'(want.granted), 32'(rsp_granted));
            if (rsp_range_begin !== want.range_begin)
               report_mismatch("range_begin", want.range_begin, rsp_range_begin);
            if (rsp_range_end !== want.range_end)
               report_mismatch("range_end", want.range_end, rsp_range_end);
            if (rsp_job_done !== want.job_done)
               report_mismatch("job_done", 32'(want.job_done), 32'(rsp_job_done));
            if (rsp_team_in_use !== want.team_in_use)
               report_mismatch("team_in_use", 32'(want.team_in_use), 32'(rsp_team_in_use));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycle_count,
                  grant_q.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_idle_claims();
      test_static();
      test_dynamic();
      test_guided();
      test_steal();
      test_mode_switch();
      test_backpressure();
      test_random();
      wait_idle();
      repeat (80) @(posedge clock);
      if (grant_q.size() != 0) report_mismatch("results never returned", 32'd0, grant_q.size());
      $display("Ran %0d transactions (%0d job starts) over %0d register settings, %0d results",
               items_sent, starts_sent, settings_used, results_seen);
      $display("Grants/claims: static %0d/%0d dynamic %0d/%0d guided %0d/%0d steal %0d/%0d",
               grants_by_mode[0], claims_by_mode[0], grants_by_mode[1], claims_by_mode[1],
               grants_by_mode[2], claims_by_mode[2], grants_by_mode[3], claims_by_mode[3]);
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

>>> sim.f
design/lcd_pkg.sv
design/loop_chunk_dispatcher.sv
tb/tb_loop_chunk_dispatcher.sv
